/* hw/rtl/assert_macros.svh */
// Assertion helper macros, clocked on clk with async reset disable.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that prop holds at every clock edge outside reset.
`define E2Q_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Check that cond at one edge implies nxt at the following edge.
`define E2Q_ASSERT_NEXT(label, cond, nxt, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (nxt)) \
		else $error(msg);
`endif

/* hw/rtl/e2q_pkg.sv */
// ----------------------------------------------------------------------------
// e2q_pkg
// Types, constants and fixed-point helpers of the Euler to quaternion core.
// ----------------------------------------------------------------------------
package e2q_pkg;

	localparam int ANGLE_BITS   = 16;
	localparam int TRIG_STAGES  = 14;
	localparam int ATAN_ENTRIES = 24;
	localparam int WORK_FRAC    = 30;
	localparam int HALF_SHIFT   = WORK_FRAC - (ANGLE_BITS - 2);
	localparam int QUEUE_DEPTH  = 4;
	localparam int WW           = 34; // working width of Q.30 values

	localparam logic signed [WW-1:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [WW-1:0] Q30_PI      = 34'sd3373259426;
	localparam logic signed [WW-1:0] Q30_HALF_PI = 34'sd1686629713;
	localparam logic signed [18:0]   Q14_ONE     = 19'sd16384;

	typedef struct packed {
		logic signed [ANGLE_BITS-1:0] roll_angle;
		logic signed [ANGLE_BITS-1:0] pitch_angle;
		logic signed [ANGLE_BITS-1:0] yaw_angle;
	} angle_t;

	typedef struct packed {
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
		logic signed [15:0] quat_w;
	} quat_t;

	// reduced half angles and cosine sign flips, lane 0 roll, 1 pitch, 2 yaw
	typedef struct packed {
		logic signed [2:0][WW-1:0] z;
		logic [2:0]                flip;
	} front_item_t;

	function automatic logic signed [WW-1:0] atan_q30(input logic [4:0] i);
		logic signed [WW-1:0] r;
		case (i)
			5'd0:  r = 34'sd843314857;
			5'd1:  r = 34'sd497837830;
			5'd2:  r = 34'sd263043837;
			5'd3:  r = 34'sd133525159;
			5'd4:  r = 34'sd67021687;
			5'd5:  r = 34'sd33543516;
			5'd6:  r = 34'sd16775851;
			5'd7:  r = 34'sd8388437;
			5'd8:  r = 34'sd4194283;
			5'd9:  r = 34'sd2097149;
			default: r = (i < 5'd24) ? (34'sd1 <<< (5'd30 - i)) : 34'sd0;
		endcase
		return r;
	endfunction

	// Q.30 product rounded half up
	function automatic logic signed [WW-1:0] mul_q30(input logic signed [WW-1:0] a,
			input logic signed [WW-1:0] b);
		logic signed [2*WW-1:0] p;
		p = (a * b) + (68'sd1 <<< (WORK_FRAC - 1));
		p = p >>> WORK_FRAC;
		return p[WW-1:0];
	endfunction

	// Q.30 sum to saturated Q1.14
	function automatic logic signed [15:0] to_q14(input logic signed [WW:0] v);
		logic signed [WW:0] t;
		logic signed [18:0] q;
		t = (v + (35'sd1 <<< (WORK_FRAC - 15))) >>> (WORK_FRAC - 14);
		q = t[18:0];
		if (q > Q14_ONE)
			q = Q14_ONE;
		else if (q < -Q14_ONE)
			q = -Q14_ONE;
		return q[15:0];
	endfunction

endpackage

/* hw/rtl/e2q_front.sv */
// ----------------------------------------------------------------------------
// e2q_front
// Halves and range-reduces the angles and queues them for the back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module e2q_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  angle_valid,
	output logic                  angle_stall,
	input  e2q_pkg::angle_t       angle,
	input  logic                  pop,
	output logic                  avail,
	output e2q_pkg::front_item_t  head
);
	localparam int D  = e2q_pkg::QUEUE_DEPTH;
	localparam int AW = $clog2(D);

	e2q_pkg::front_item_t mem_q [D];
	e2q_pkg::front_item_t item;
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;
	logic          push;
	logic signed [e2q_pkg::ANGLE_BITS-1:0] raw [3];

	assign raw[0] = angle.roll_angle;
	assign raw[1] = angle.pitch_angle;
	assign raw[2] = angle.yaw_angle;

	always_comb begin
		logic signed [e2q_pkg::WW-1:0] h;
		item = '0;
		for (int l = 0; l < 3; l++) begin
			h = e2q_pkg::WW'(raw[l]) <<< e2q_pkg::HALF_SHIFT;
			if (h > e2q_pkg::Q30_HALF_PI) begin
				item.z[l] = e2q_pkg::Q30_PI - h;
				item.flip[l] = 1'b1;
			end else if (h < -e2q_pkg::Q30_HALF_PI) begin
				item.z[l] = -e2q_pkg::Q30_PI - h;
				item.flip[l] = 1'b1;
			end else begin
				item.z[l] = h;
				item.flip[l] = 1'b0;
			end
		end
	end

	assign angle_stall = (cnt_q == (AW+1)'(D));
	assign push  = angle_valid && !angle_stall;
	assign avail = (cnt_q != '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop && avail)
				rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop && avail);
		end
	end

	`E2Q_ASSERT(a_cnt_bound, cnt_q <= (AW+1)'(D), "queue count above depth")
	`E2Q_ASSERT_NEXT(a_empty_next, cnt_q == '0 && !push, cnt_q == '0, "queue filled with no push")
	`E2Q_ASSERT_NEXT(a_pop_dec, cnt_q == (AW+1)'(1) && pop && !push, !avail,
		"queue not empty after last pop")
endmodule

/* hw/rtl/e2q_back.sv */
// ----------------------------------------------------------------------------
// e2q_back
// CORDIC sine/cosine pipeline, quaternion products and output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module e2q_back #(
	parameter int TRIG_STAGES = e2q_pkg::TRIG_STAGES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  avail,
	input  e2q_pkg::front_item_t  head,
	output logic                  pop,
	output logic                  quat_valid,
	input  logic                  quat_stall,
	output e2q_pkg::quat_t        quat
);
	localparam int N  = (TRIG_STAGES > e2q_pkg::ATAN_ENTRIES) ? e2q_pkg::ATAN_ENTRIES
		: TRIG_STAGES;
	localparam int W  = e2q_pkg::WW;
	localparam int NV = N + 4;

	logic en;
	logic [NV-1:0] vld_q;
	logic signed [2:0][W-1:0] x_s [N+1];
	logic signed [2:0][W-1:0] y_s [N+1];
	logic signed [2:0][W-1:0] z_s [N+1];
	logic [2:0] flip_s [N+1];
	// first products: srcp, crsp, crcp, srsp; yaw sine and cosine ride along
	logic signed [W-1:0] srcp_s1, crsp_s1, crcp_s1, srsp_s1, sy_s1, cy_s1;
	logic signed [W-1:0] t_s2 [8];
	e2q_pkg::quat_t quat_q;

	// whole pipeline advances unless the result register is held
	assign en  = !(quat_valid && quat_stall);
	assign pop = en && avail;
	assign quat_valid = vld_q[NV-1];
	assign quat = quat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[NV-2:0], avail};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				x_s[0][l] <= e2q_pkg::CORDIC_GAIN;
				y_s[0][l] <= '0;
				z_s[0][l] <= head.z[l];
			end
			flip_s[0] <= head.flip;
		end
	end

	// lane elements of the packed arrays are unsigned selects, hence $signed
	for (genvar k = 0; k < N; k++) begin : g_cordic
		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < 3; l++) begin
					if ($signed(z_s[k][l]) >= 0) begin
						x_s[k+1][l] <= $signed(x_s[k][l]) - ($signed(y_s[k][l]) >>> k);
						y_s[k+1][l] <= $signed(y_s[k][l]) + ($signed(x_s[k][l]) >>> k);
						z_s[k+1][l] <= z_s[k][l] - e2q_pkg::atan_q30(5'(k));
					end else begin
						x_s[k+1][l] <= $signed(x_s[k][l]) + ($signed(y_s[k][l]) >>> k);
						y_s[k+1][l] <= $signed(y_s[k][l]) - ($signed(x_s[k][l]) >>> k);
						z_s[k+1][l] <= z_s[k][l] + e2q_pkg::atan_q30(5'(k));
					end
				end
				flip_s[k+1] <= flip_s[k];
			end
		end
	end

	logic signed [W-1:0] s_c [3];
	logic signed [W-1:0] c_c [3];
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			s_c[l] = y_s[N][l];
			c_c[l] = flip_s[N][l] ? -x_s[N][l] : x_s[N][l];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			srcp_s1 <= e2q_pkg::mul_q30(s_c[0], c_c[1]);
			crsp_s1 <= e2q_pkg::mul_q30(c_c[0], s_c[1]);
			crcp_s1 <= e2q_pkg::mul_q30(c_c[0], c_c[1]);
			srsp_s1 <= e2q_pkg::mul_q30(s_c[0], s_c[1]);
			sy_s1   <= s_c[2];
			cy_s1   <= c_c[2];
			t_s2[0] <= e2q_pkg::mul_q30(srcp_s1, cy_s1);
			t_s2[1] <= e2q_pkg::mul_q30(crsp_s1, sy_s1);
			t_s2[2] <= e2q_pkg::mul_q30(crsp_s1, cy_s1);
			t_s2[3] <= e2q_pkg::mul_q30(srcp_s1, sy_s1);
			t_s2[4] <= e2q_pkg::mul_q30(crcp_s1, sy_s1);
			t_s2[5] <= e2q_pkg::mul_q30(srsp_s1, cy_s1);
			t_s2[6] <= e2q_pkg::mul_q30(crcp_s1, cy_s1);
			t_s2[7] <= e2q_pkg::mul_q30(srsp_s1, sy_s1);
			quat_q.quat_x <= e2q_pkg::to_q14((W+1)'(t_s2[0]) - (W+1)'(t_s2[1]));
			quat_q.quat_y <= e2q_pkg::to_q14((W+1)'(t_s2[2]) + (W+1)'(t_s2[3]));
			quat_q.quat_z <= e2q_pkg::to_q14((W+1)'(t_s2[4]) - (W+1)'(t_s2[5]));
			quat_q.quat_w <= e2q_pkg::to_q14((W+1)'(t_s2[6]) + (W+1)'(t_s2[7]));
		end
	end

	`E2Q_ASSERT_NEXT(a_hold, !en, $stable(vld_q), "pipeline moved while result held")
	`E2Q_ASSERT(a_pop_avail, !pop || avail, "pop from empty queue")
	`E2Q_ASSERT_NEXT(a_fill, pop, vld_q[0], "popped item lost at pipeline entry")
endmodule

/* hw/rtl/euler_to_quaternion_core.sv */
// ----------------------------------------------------------------------------
// euler_to_quaternion_core
// ZYX Euler angles (Q3.13 rad) to unit quaternion (Q1.14), streaming.
// ----------------------------------------------------------------------------
// Takes one angle transaction per cycle while angle_stall is low and returns
// one quaternion transaction for each, in order. Each result passes one queue
// slot, the pipeline input register, one register per CORDIC iteration (three
// lanes side by side, capped at 24 iterations), two product stages and the
// output register. A four-entry queue separates the angle front end from the
// arithmetic; angle_stall rises only when that queue is full, which happens
// when quat_stall holds the output long enough. Results saturate at +/-16384.
module euler_to_quaternion_core #(
	parameter int TRIG_STAGES = e2q_pkg::TRIG_STAGES
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            angle_valid,
	output logic            angle_stall,
	input  e2q_pkg::angle_t angle,
	output logic            quat_valid,
	input  logic            quat_stall,
	output e2q_pkg::quat_t  quat
);
	e2q_pkg::front_item_t head;
	logic avail, pop;

	// front end: halve, fold into +/-pi/2, queue
	e2q_front u_front (
		.clk(clk), .arst_n(arst_n),
		.angle_valid(angle_valid), .angle_stall(angle_stall), .angle(angle),
		.pop(pop), .avail(avail), .head(head)
	);

	// back end: CORDIC, products, rounding and saturation
	e2q_back #(.TRIG_STAGES(TRIG_STAGES)) u_back (
		.clk(clk), .arst_n(arst_n),
		.avail(avail), .head(head), .pop(pop),
		.quat_valid(quat_valid), .quat_stall(quat_stall), .quat(quat)
	);
endmodule
